// ----- hw/rtl/gnmc_pkg.sv -----
// Shared constants and types for the grid nearest marked cell block.
package gnmc_pkg;

  localparam int GRID_DIM = 64;
  localparam int IDX_W    = $clog2(GRID_DIM);
  localparam int CFG_W    = IDX_W + 1;
  localparam int DIST_W   = 30;
  localparam int SQ_W     = 2 * IDX_W;
  localparam int BEST_W   = SQ_W + 1;

  localparam logic [DIST_W-1:0] NO_MARK_DISTANCE = DIST_W'(1 << 29);

  // Input function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOAD_WR = 7'b0000010,
    S_ROW_RD  = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_MARK_RD = 7'b0010000,
    S_MARK_WR = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

endpackage

// ----- hw/rtl/grid_nearest_marked_cell.sv -----
// Top level: mark bitmap and the sequenced nearest marked cell search.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   func, row, col, mark
//   out      from block out_valid/out_stall distance, found
//   cfg      to block   cfg_we              cfg_index, cfg_data
//
// A load item inside the area in use reads the row of the cell, then writes
// it back with the one bit changed. The length of a query item is set by the
// single distance and compare unit that looks at one cell a cycle, plus one
// row read per grid row; a query then marks its own cell. A query on a cell
// outside the area in use skips the final mark.
// Reset clears the control state and the per-row valid bits, so every row of
// the mark memory reads as unmarked until it is first written.
// A finished result waits in the output register; the block takes the next
// item meanwhile and only waits when a second result would overwrite it.
module grid_nearest_marked_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [gnmc_pkg::IDX_W-1:0]    row,
  input  logic [gnmc_pkg::IDX_W-1:0]    col,
  input  logic                          mark,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gnmc_pkg::DIST_W-1:0]   distance,
  output logic                          found,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gnmc_pkg::CFG_W-1:0]    cfg_data
);
  import gnmc_pkg::*;

  state_t state, state_next;

  // Configuration registers, held raw and clamped to the grid when used.
  logic [CFG_W-1:0] rows_cfg, cols_cfg;
  logic [CFG_W-1:0] nr, nc;

  // Captured item.
  logic             func_q, mark_q, inside_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic             inside_in;

  // Scan counters and the running minimum.
  logic [IDX_W-1:0]  r_cnt, c_cnt;
  logic [BEST_W-1:0] best;
  logic              any_found;

  // Mark memory: one word per grid row, with a valid bit per row so that
  // reset needs no clearing pass.
  logic [GRID_DIM-1:0] mem [GRID_DIM];
  logic [GRID_DIM-1:0] mem_q;
  logic [GRID_DIM-1:0] row_valid;
  logic                q_valid;
  logic [GRID_DIM-1:0] row_data;
  logic                mem_re, mem_we;
  logic [IDX_W-1:0]    raddr;
  logic [GRID_DIM-1:0] wdata;

  // Shared distance unit.
  logic [IDX_W-1:0]  dr, dc;
  logic [SQ_W-1:0]   sq_r, sq_c;
  logic [BEST_W-1:0] cell_dist;
  logic              cell_hit;
  logic              last_col, last_row;

  assign nr = (rows_cfg > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : rows_cfg;
  assign nc = (cols_cfg > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : cols_cfg;
  assign inside_in = ({1'b0, row} < nr) && ({1'b0, col} < nc);

  assign in_stall = (state != S_IDLE);

  assign row_data = q_valid ? mem_q : '0;

  assign dr   = (r_cnt > row_q) ? (r_cnt - row_q) : (row_q - r_cnt);
  assign dc   = (c_cnt > col_q) ? (c_cnt - col_q) : (col_q - c_cnt);
  assign sq_r = SQ_W'(dr) * SQ_W'(dr);
  assign sq_c = SQ_W'(dc) * SQ_W'(dc);
  assign cell_dist = BEST_W'(sq_r) + BEST_W'(sq_c);
  assign cell_hit = row_data[c_cnt];

  assign last_col = ({1'b0, c_cnt} == (nc - CFG_W'(1)));
  assign last_row = ({1'b0, r_cnt} == (nr - CFG_W'(1)));

  // Memory port selection.
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = row;
    wdata  = row_data;
    unique case (state)
      S_IDLE: begin
        mem_re = 1'b1;
        raddr  = row;
      end
      S_ROW_RD: begin
        mem_re = 1'b1;
        raddr  = r_cnt;
      end
      S_MARK_RD: begin
        mem_re = 1'b1;
        raddr  = row_q;
      end
      S_LOAD_WR: begin
        mem_we       = 1'b1;
        wdata[col_q] = mark_q;
      end
      S_MARK_WR: begin
        mem_we       = 1'b1;
        wdata[col_q] = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_q] <= wdata;
    end
    if (mem_re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid   <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[row_q] <= 1'b1;
      end
      if (mem_re) begin
        q_valid <= row_valid[raddr];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_LOAD) begin
            state_next = inside_in ? S_LOAD_WR : S_IDLE;
          end else if ((nr == '0) || (nc == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ROW_RD;
          end
        end
      end
      S_LOAD_WR: state_next = S_IDLE;
      S_ROW_RD:  state_next = S_SCAN;
      S_SCAN: begin
        if (last_col) begin
          if (last_row) begin
            state_next = inside_q ? S_MARK_RD : S_DONE;
          end else begin
            state_next = S_ROW_RD;
          end
        end
      end
      S_MARK_RD: state_next = S_MARK_WR;
      S_MARK_WR: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rows_cfg  <= CFG_W'(GRID_DIM);
      cols_cfg  <= CFG_W'(GRID_DIM);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_cfg <= cfg_data;
          REG_COLS: cols_cfg <= cfg_data;
          default:  rows_cfg <= rows_cfg;
        endcase
      end
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, scan counters and running minimum.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      func_q    <= func;
      row_q     <= row;
      col_q     <= col;
      mark_q    <= mark;
      inside_q  <= inside_in;
      r_cnt     <= '0;
      c_cnt     <= '0;
      best      <= '0;
      any_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (cell_hit) begin
        if (!any_found || (cell_dist < best)) begin
          best <= cell_dist;
        end
        any_found <= 1'b1;
      end
      if (last_col) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + IDX_W'(1);
      end else begin
        c_cnt <= c_cnt + IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      distance <= any_found ? DIST_W'(best) : NO_MARK_DISTANCE;
      found    <= any_found;
    end
  end

  // The mark memory is never read and written in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("mark memory read and write in the same cycle");

  // Only queries reach the scan and the final result.
  a_scan_is_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DONE) |-> (func_q == FUNC_QUERY))
    else $error("load item entered the query path");

  // A result without a marked cell carries the sentinel distance.
  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (distance == NO_MARK_DISTANCE))
    else $error("no-mark result without sentinel distance");

  // The scan stays inside the area in use.
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (({1'b0, c_cnt} < nc) && ({1'b0, r_cnt} < nr)))
    else $error("scan outside the area in use");

  // Reset leaves every row of the mark memory unmarked.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (row_valid == '0))
    else $error("row valid bits not cleared by reset");

endmodule

// ----- tb/sv/gnmc_nearest_checker.sv -----
// Checker for the grid nearest marked cell block: mirrors the mark map and compares answers.
module gnmc_nearest_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          func,
  input  logic [gnmc_pkg::IDX_W-1:0]    row,
  input  logic [gnmc_pkg::IDX_W-1:0]    col,
  input  logic                          mark,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gnmc_pkg::DIST_W-1:0]   distance,
  input  logic                          found,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gnmc_pkg::CFG_W-1:0]    cfg_data,
  output int unsigned                   pending,
  output int unsigned                   fail_count
);
  import gnmc_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              found;
  } nearest_t;

  bit               marked [GRID_DIM][GRID_DIM];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  nearest_t         pending_answers [$];
  int unsigned      queued = 0;
  int unsigned      mismatches = 0;

  assign pending    = queued;
  assign fail_count = mismatches;

  // Exhaustive search over the cells in use; the first marked cell seeds the minimum.
  function automatic nearest_t nearest_mark_distance(int qr, int qc, int nr, int nc);
    nearest_t best;
    int       dr;
    int       dc;
    int       d;
    best.distance = NO_MARK_DISTANCE;
    best.found    = 1'b0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (marked[r][c]) begin
          dr = r - qr;
          dc = c - qc;
          d  = dr * dr + dc * dc;
          if (!best.found || d < int'(best.distance)) best.distance = DIST_W'(d);
          best.found = 1'b1;
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : watch
    nearest_t want;
    int       nr;
    int       nc;
    logic     in_area;
    if (rst) begin
      for (int r = 0; r < GRID_DIM; r++) begin
        for (int c = 0; c < GRID_DIM; c++) marked[r][c] = 1'b0;
      end
      rows_reg = CFG_W'(GRID_DIM);
      cols_reg = CFG_W'(GRID_DIM);
      pending_answers.delete();
    end else begin
      // Results are checked before new items are predicted, so an answer leaving
      // on the same edge as a query arrives is matched against older queries.
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result: distance %0d, found %0b", distance, found);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, distance);
            mismatches++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        nr      = (rows_reg > GRID_DIM) ? GRID_DIM : int'(rows_reg);
        nc      = (cols_reg > GRID_DIM) ? GRID_DIM : int'(cols_reg);
        in_area = (int'(row) < nr) && (int'(col) < nc);
        if (func == FUNC_QUERY) begin
          pending_answers.push_back(nearest_mark_distance(int'(row), int'(col), nr, nc));
          if (in_area) marked[row][col] = 1'b1;
        end else if (in_area) begin
          marked[row][col] = mark;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
      end
    end
    queued = pending_answers.size();
  end

endmodule

// ----- tb/sv/grid_nearest_marked_cell_tb.sv -----
// Top level testbench for the grid nearest marked cell block: stimulus and verdict.
module grid_nearest_marked_cell_tb;
  import gnmc_pkg::*;

  // A full 64 by 64 query scans every cell of the grid, and the stimulus below runs
  // at most sixteen of those. Everything else uses small grids, so a correct
  // run stays far below this many cycles even with the longest stalls.
  localparam int LIMIT_CYCLES = 800_000;
  localparam int PHASES = 12;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [IDX_W-1:0]    row;
  logic [IDX_W-1:0]    col;
  logic                mark;
  logic                out_valid;
  logic                out_stall;
  logic [DIST_W-1:0]   distance;
  logic                found;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  int unsigned         pending;
  int unsigned         fail_count;

  // When set, the sender offers items back to back with no gaps.
  bit calm;

  // Grid settings of the random phases. Values of zero and values above the
  // grid size are legal register contents and are exercised on purpose; the
  // full-size phases carry only a few items because every query scans the grid.
  int phase_rows  [PHASES] = '{1, 8, 0, 127, 4, 16, 64, 5, 2, 12, 64, 70};
  int phase_cols  [PHASES] = '{1, 5, 12, 3, 100, 16, 64, 64, 2, 9, 1, 70};
  int phase_items [PHASES] = '{10, 12, 8, 12, 12, 16, 6, 12, 8, 12, 10, 4};

  grid_nearest_marked_cell i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .row       (row),
    .col       (col),
    .mark      (mark),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .distance  (distance),
    .found     (found),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gnmc_nearest_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .row        (row),
    .col        (col),
    .mark       (mark),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance   (distance),
    .found      (found),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Offers one item after a random gap and returns at the falling edge after it
  // was taken. Valid stays high on return, so the next item can follow without
  // a bubble; whoever pauses the sender lowers it.
  task automatic send_item(input logic f, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic m);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func     = f;
    row      = r;
    col      = c;
    mark     = m;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every query has been answered. A load gives no answer and keeps
  // the block busy while it writes its row, so a pause follows as well.
  task automatic drain_and_settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Changes the area in use; only done while the block is idle.
  task automatic set_grid(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
    drain_and_settle();
    cfg_we    = 1'b1;
    cfg_index = REG_ROWS;
    cfg_data  = nrows;
    @(negedge clk);
    cfg_index = REG_COLS;
    cfg_data  = ncols;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // The receiver stalls at random: short stalls most of the time, a few long
  // ones, and now and then a long stretch where it takes every result at once.
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(30, 150)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int               nr;
    int               nc;
    logic             f;
    logic             m;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;

    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_LOAD;
    row       = '0;
    col       = '0;
    mark      = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed part, first on the full grid that reset leaves in use.
    // A query on an empty grid answers with the sentinel and marks its cell.
    send_item(FUNC_QUERY, 6'd0, 6'd0, 1'b0);
    // The far corner sees the one mark at the opposite corner; the mark field
    // of a query is ignored.
    send_item(FUNC_QUERY, 6'd63, 6'd63, 1'b1);
    // Clearing both marks empties the grid again.
    send_item(FUNC_LOAD, 6'd63, 6'd63, 1'b0);
    send_item(FUNC_LOAD, 6'd0, 6'd0, 1'b0);
    send_item(FUNC_QUERY, 6'd63, 6'd0, 1'b0);
    // A query on a cell that is already marked answers zero.
    send_item(FUNC_LOAD, 6'd0, 6'd63, 1'b1);
    send_item(FUNC_QUERY, 6'd0, 6'd63, 1'b0);
    send_item(FUNC_LOAD, 6'd21, 6'd42, 1'b1);
    send_item(FUNC_QUERY, 6'd42, 6'd21, 1'b0);

    // With no rows in use every query gets the sentinel although marks are
    // stored, and loads are ignored.
    set_grid(7'd0, 7'd12);
    send_item(FUNC_QUERY, 6'd0, 6'd0, 1'b0);
    send_item(FUNC_LOAD, 6'd0, 6'd5, 1'b1);

    // A tiny area: loads outside it are dropped, and a query outside it is
    // answered from the marks inside but leaves no mark, so it repeats.
    set_grid(7'd2, 7'd2);
    send_item(FUNC_LOAD, 6'd1, 6'd1, 1'b1);
    send_item(FUNC_LOAD, 6'd40, 6'd40, 1'b1);
    send_item(FUNC_QUERY, 6'd5, 6'd5, 1'b0);
    send_item(FUNC_QUERY, 6'd5, 6'd5, 1'b0);
    send_item(FUNC_QUERY, 6'd0, 6'd0, 1'b0);

    // Register values above the grid act as the full grid, and the marks kept
    // outside the small area count again.
    set_grid(7'd127, 7'd65);
    send_item(FUNC_QUERY, 6'd63, 6'd62, 1'b0);
    send_item(FUNC_LOAD, 6'd63, 6'd0, 1'b0);

    // Random part. Most items fall inside the area in use and most loads set
    // a mark, so queries see well-filled grids; the rest may land anywhere.
    for (int p = 0; p < PHASES; p++) begin
      set_grid(CFG_W'(phase_rows[p]), CFG_W'(phase_cols[p]));
      nr   = (phase_rows[p] > GRID_DIM) ? GRID_DIM : phase_rows[p];
      nc   = (phase_cols[p] > GRID_DIM) ? GRID_DIM : phase_cols[p];
      calm = ($urandom_range(0, 3) == 0);
      repeat (phase_items[p]) begin
        f = ($urandom_range(0, 9) < 4) ? FUNC_QUERY : FUNC_LOAD;
        m = ($urandom_range(0, 9) < 7);
        if (nr > 0 && nc > 0 && $urandom_range(0, 4) != 0) begin
          r = IDX_W'($urandom_range(0, nr - 1));
          c = IDX_W'($urandom_range(0, nc - 1));
        end else begin
          r = IDX_W'($urandom_range(0, GRID_DIM - 1));
          c = IDX_W'($urandom_range(0, GRID_DIM - 1));
        end
        send_item(f, r, c, m);
      end
    end

    calm = 1'b0;
    drain_and_settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
